// File: src/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared geometry, codes and stream field layout of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int COL_W      = $clog2(COLUMNS + 1);

	// stream and register port widths
	localparam int IN_W      = 24;
	localparam int OUT_W     = 32;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int OP_W      = 2;
	localparam int CHAR_W    = 8;
	localparam int INDEX_W   = 11;
	localparam int ROW_OUT_W = 5;
	localparam int COL_OUT_W = 7;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [3:0]        RESET_FG     = 4'hF;
	localparam logic [3:0]        RESET_BG     = 4'h0;

	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic {
		REG_FG = 1'b0,
		REG_BG = 1'b1
	} reg_idx_t;

endpackage : tcw_pkg
`default_nettype wire

// File: src/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: character/attribute screen store, cursor, scrolling.
// ----------------------------------------------------------------------------
// The screen lives in one synchronous RAM of COLUMNS x ROWS cells with one
// read and one write port that moves one cell per cycle, and every request
// returns one result with the cursor after it. A printable character that
// stays on its row is written in the accepting cycle; one that wraps to the
// next row is written from S_WRITE. A cell read goes through S_READ unless
// the index is off the screen. A clear walks the whole store. A newline or
// wrap on the last row scrolls: S_SCROLL copies each row but the top one up
// by one row, S_BLANK blanks the bottom row, and a wrapped character is then
// written in S_WRITE. After reset the store is blanked in S_INIT by a pass
// over every cell during which no
// request is taken; colour registers can be written at any time. A new
// request is taken while the previous result still waits on the output; the
// result of that request then waits until the output is free.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// apb register port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tcw_pkg::PADDR_W-1:0] paddr,
	input  wire logic [tcw_pkg::PDATA_W-1:0] pwdata,
	output logic      [tcw_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	// request stream
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [tcw_pkg::IN_W-1:0]    s_tdata,  // op, character, cell_index
	// result stream
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [tcw_pkg::OUT_W-1:0]   m_tdata   // cell_character, cell_attribute,
	                                                   // cursor_row, cursor_column
);
	import tcw_pkg::*;

	typedef enum logic [7:0] {
		S_INIT   = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_READ   = 8'b0000_0100,
		S_CLEAR  = 8'b0000_1000,
		S_SCROLL = 8'b0001_0000,
		S_BLANK  = 8'b0010_0000,
		S_WRITE  = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   dst_s1;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [3:0]          fg_q;
	logic [3:0]          bg_q;
	logic [CHAR_W-1:0]   ch_q;
	logic                put_after_q;
	logic [CHAR_W-1:0]   res_chr_q;
	logic [CHAR_W-1:0]   res_att_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic [15:0]         mem [CELL_COUNT];
	logic [15:0]         rd_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_wa;
	logic [15:0]         mem_wd;
	logic [ADDR_W-1:0]   mem_ra;

	logic [OP_W-1:0]     in_op;
	logic [CHAR_W-1:0]   in_ch;
	logic [INDEX_W-1:0]  in_ci;
	logic                in_fire;
	logic                direct_put;
	logic                last_row;
	logic                col_full;
	logic [CHAR_W-1:0]   cur_attr;
	logic [ADDR_W-1:0]   cur_idx;
	logic                out_free;
	logic                cfg_wr;

	assign in_op    = s_tdata[1:0];
	assign in_ch    = s_tdata[9:2];
	assign in_ci    = s_tdata[20:10];
	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	assign last_row   = (row_q == ROW_W'(ROWS - 1));
	assign col_full   = (col_q >= COL_W'(COLUMNS));
	assign direct_put = (in_op == OP_PUT) && (in_ch != NEWLINE_CODE) && !col_full;
	assign cur_attr   = {bg_q, fg_q};
	assign cur_idx    = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
	assign out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_FG:  prdata = PDATA_W'(fg_q);
			REG_BG:  prdata = PDATA_W'(bg_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= RESET_FG;
			bg_q <= RESET_BG;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_FG:  fg_q <= pwdata[3:0];
				REG_BG:  bg_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// screen store port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = {RESET_BG, RESET_FG, SPACE_CODE};
		mem_ra = addr_q;
		case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_CLEAR, S_BLANK: begin
				mem_we = 1'b1;
				mem_wd = {cur_attr, SPACE_CODE};
			end
			S_SCROLL: begin
				mem_ra = ADDR_W'(32'(addr_q) + COLUMNS);
				mem_we = (addr_q != '0);
				mem_wa = dst_s1;
				mem_wd = rd_q;
			end
			S_WRITE: begin
				mem_we = 1'b1;
				mem_wa = cur_idx;
				mem_wd = {cur_attr, ch_q};
			end
			S_IDLE: begin
				mem_ra = ADDR_W'(in_ci);
				mem_we = in_fire && direct_put;
				mem_wa = cur_idx;
				mem_wd = {cur_attr, in_ch};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q   <= mem[mem_ra];
		dst_s1 <= addr_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			addr_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			ch_q        <= '0;
			put_after_q <= 1'b0;
			res_chr_q   <= '0;
			res_att_q   <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (addr_q == ADDR_W'(CELL_COUNT - 1)) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						res_chr_q   <= '0;
						res_att_q   <= '0;
						ch_q        <= in_ch;
						addr_q      <= '0;
						put_after_q <= 1'b0;
						case (in_op)
							OP_PUT: begin
								if (in_ch == NEWLINE_CODE) begin
									col_q <= '0;
									if (!last_row) begin
										row_q   <= row_q + 1'b1;
										state_q <= S_DONE;
									end else begin
										state_q <= S_SCROLL;
									end
								end else if (col_full) begin
									col_q <= '0;
									if (!last_row) begin
										row_q   <= row_q + 1'b1;
										state_q <= S_WRITE;
									end else begin
										put_after_q <= 1'b1;
										state_q     <= S_SCROLL;
									end
								end else begin
									col_q   <= col_q + 1'b1;
									state_q <= S_DONE;
								end
							end
							OP_CLEAR: state_q <= S_CLEAR;
							OP_READ: begin
								if (32'(in_ci) < CELL_COUNT) begin
									state_q <= S_READ;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_READ: begin
					res_chr_q <= rd_q[7:0];
					res_att_q <= rd_q[15:8];
					state_q   <= S_DONE;
				end
				S_CLEAR: begin
					if (addr_q == ADDR_W'(CELL_COUNT - 1)) begin
						state_q <= S_DONE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_SCROLL: begin
					if (addr_q == ADDR_W'(CELL_COUNT - COLUMNS)) begin
						state_q <= S_BLANK;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_BLANK: begin
					if (addr_q == ADDR_W'(CELL_COUNT - 1)) begin
						state_q <= put_after_q ? S_WRITE : S_DONE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_WRITE: begin
					col_q   <= col_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0000, COL_OUT_W'(col_q), ROW_OUT_W'(row_q),
						               res_att_q, res_chr_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule : text_console_writer
`default_nettype wire

// File: src/tcw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [tcw_pkg::OUT_W-1:0] m_tdata
);
	import tcw_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// cursor stays on screen
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[20:16]) < ROWS)
		else $error("cursor row off screen");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[27:21]) <= COLUMNS)
		else $error("cursor column beyond line end");

endmodule : tcw_checker

bind text_console_writer tcw_checker u_tcw_checker (.*);
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. Requests go in on the
// request stream with random gaps while the result stream stalls at random.
// A scoreboard keeps its own screen, cursor and colours, works out the
// result of every accepted request and checks each returned result.
// ----------------------------------------------------------------------------
module tb_top;

	import tcw_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int CHUNKS = 6;
	localparam int CHUNK_ITEMS = 105;

	typedef struct {
		logic [CHAR_W-1:0]    chr;
		logic [7:0]           attr;
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
	} cell_result_t;

	class console_scoreboard;
		logic [CHAR_W-1:0] glyph_store [CELL_COUNT];
		logic [7:0]        attr_store [CELL_COUNT];
		int unsigned       row;
		int unsigned       col;
		logic [3:0]        fg;
		logic [3:0]        bg;
		cell_result_t      awaited [$];
		int                errors;

		function new();
			int unsigned i;
			for (i = 0; i < CELL_COUNT; i++) begin
				glyph_store[i] = SPACE_CODE;
				attr_store[i] = {RESET_BG, RESET_FG};
			end
			row = 0;
			col = 0;
			fg = RESET_FG;
			bg = RESET_BG;
			errors = 0;
		endfunction

		function logic [7:0] attr_now();
			return {bg, fg};
		endfunction

		function void blank_row(int unsigned r);
			int unsigned c;
			for (c = 0; c < COLUMNS; c++) begin
				glyph_store[r * COLUMNS + c] = SPACE_CODE;
				attr_store[r * COLUMNS + c] = attr_now();
			end
		endfunction

		// next row, or scroll everything up one row when on the bottom row
		function void newline();
			int unsigned i;
			col = 0;
			if (row + 1 < ROWS) begin
				row++;
				return;
			end
			for (i = 0; i < CELL_COUNT - COLUMNS; i++) begin
				glyph_store[i] = glyph_store[i + COLUMNS];
				attr_store[i] = attr_store[i + COLUMNS];
			end
			blank_row(ROWS - 1);
		endfunction

		function void set_colour(reg_idx_t which, logic [3:0] value);
			if (which == REG_FG)
				fg = value;
			else
				bg = value;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
				logic [INDEX_W-1:0] idx);
			cell_result_t res;
			int unsigned pos;
			int unsigned r;
			res.chr = '0;
			res.attr = '0;
			case (op)
				OP_PUT: begin
					if (ch == NEWLINE_CODE) begin
						newline();
					end else begin
						if (col >= COLUMNS)
							newline();
						pos = row * COLUMNS + col;
						if (pos < CELL_COUNT) begin
							glyph_store[pos] = ch;
							attr_store[pos] = attr_now();
						end
						col++;
					end
				end
				OP_CLEAR: begin
					for (r = 0; r < ROWS; r++)
						blank_row(r);
				end
				OP_READ: begin
					if (idx < CELL_COUNT) begin
						res.chr = glyph_store[idx];
						res.attr = attr_store[idx];
					end
				end
				default: ;
			endcase
			res.row = row[ROW_OUT_W-1:0];
			res.col = col[COL_OUT_W-1:0];
			awaited.push_back(res);
		endfunction

		function void report(string field, int exp_val, int act_val);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
				exp_val, act_val);
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			cell_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with nothing awaited, expected none, actual 0x%08h",
					$time, data);
				return;
			end
			want = awaited.pop_front();
			if (data[7:0] !== want.chr)
				report("cell_character", want.chr, data[7:0]);
			if (data[15:8] !== want.attr)
				report("cell_attribute", want.attr, data[15:8]);
			if (data[20:16] !== want.row)
				report("cursor_row", want.row, data[20:16]);
			if (data[27:21] !== want.col)
				report("cursor_column", want.col, data[27:21]);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;   // op, character, cell_index, zero pad
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;        // cell_character, cell_attribute,
	                                     // cursor_row, cursor_column, zero pad

	int tx_idle_pct = 30;
	int rx_idle_pct = 65;
	int line_left = 0;
	console_scoreboard board;

	text_console_writer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	task automatic send_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
			logic [INDEX_W-1:0] idx);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, idx, ch, op};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_request(op, ch, idx);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_colour(reg_idx_t which, logic [3:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= {28'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_colour(which, value);
		@(posedge clk);
	endtask

	// mostly lines of printable text ending in a newline, some long enough
	// to wrap, with reads, clears and unused codes mixed in
	task automatic run_random(int count);
		int n;
		int pick;
		logic [CHAR_W-1:0] ch;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if (line_left == 0) begin
					send_request(OP_PUT, NEWLINE_CODE, INDEX_W'($urandom));
					line_left = ($urandom_range(0, 99) < 8) ? $urandom_range(76, 86)
						: $urandom_range(0, 12);
				end else begin
					ch = CHAR_W'($urandom);
					if (ch == NEWLINE_CODE)
						ch = SPACE_CODE;
					send_request(OP_PUT, ch, INDEX_W'($urandom));
					line_left--;
				end
			end else if (pick < 86) begin
				send_request(OP_READ, CHAR_W'($urandom),
					($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(CELL_COUNT, 2047))
					: INDEX_W'($urandom_range(0, CELL_COUNT - 1)));
			end else if (pick < 94) begin
				send_request(OP_READ, CHAR_W'($urandom),
					INDEX_W'(board.row * COLUMNS + $urandom_range(0, COLUMNS - 1)));
			end else if (pick < 96) begin
				send_request(OP_UNUSED, CHAR_W'($urandom), INDEX_W'($urandom));
			end else if (pick < 97) begin
				send_request(OP_CLEAR, CHAR_W'($urandom), INDEX_W'($urandom));
			end else begin
				send_request(OP_PUT, CHAR_W'($urandom), INDEX_W'($urandom));
			end
		end
	endtask

	initial begin
		#400ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int k;
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset contents, edges of the store and out of range reads
		send_request(OP_READ, 8'h00, 11'd0);
		send_request(OP_READ, 8'hFF, INDEX_W'(CELL_COUNT - 1));
		send_request(OP_READ, 8'h00, INDEX_W'(CELL_COUNT));
		send_request(OP_READ, 8'hFF, 11'h7FF);
		// extreme characters, newline, unused code
		send_request(OP_PUT, 8'h00, 11'h7FF);
		send_request(OP_PUT, 8'hFF, 11'h000);
		send_request(OP_PUT, 8'h41, 11'h555);
		send_request(OP_PUT, NEWLINE_CODE, 11'h2AA);
		send_request(OP_PUT, 8'h7E, 11'h0);
		send_request(OP_UNUSED, 8'hFF, 11'h7FF);
		send_request(OP_READ, 8'h00, 11'd0);
		send_request(OP_READ, 8'h00, 11'd1);
		send_request(OP_READ, 8'h00, 11'd2);
		send_request(OP_READ, 8'h00, INDEX_W'(COLUMNS));
		send_request(OP_CLEAR, 8'h00, 11'h0);
		send_request(OP_READ, 8'h00, 11'd0);
		send_request(OP_READ, 8'h00, INDEX_W'(COLUMNS));

		for (k = 0; k < CHUNKS; k++) begin
			wait_drained();
			case (k)
				0: begin
					write_colour(REG_FG, 4'h0);
					write_colour(REG_BG, 4'hF);
				end
				1: begin
					write_colour(REG_BG, 4'h0);
					write_colour(REG_FG, 4'hF);
				end
				2: begin
					write_colour(REG_FG, 4'hF);
					write_colour(REG_BG, 4'hF);
				end
				3: begin
					write_colour(REG_FG, 4'h0);
					write_colour(REG_BG, 4'h0);
				end
				default: begin
					write_colour(REG_FG, 4'($urandom));
					write_colour(REG_BG, 4'($urandom));
				end
			endcase
			case (k / 2)
				0: begin
					tx_idle_pct = 30;
					rx_idle_pct = 65;
				end
				1: begin
					tx_idle_pct = 65;
					rx_idle_pct = 30;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			run_random(CHUNK_ITEMS);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.awaited.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
